@@ rtl/layer_z_order_manager_defines.svh @@
// Assertion macros shared by the layer z-order manager RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef LAYER_Z_ORDER_MANAGER_DEFINES_SVH
`define LAYER_Z_ORDER_MANAGER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define LZOM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LZOM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lzom_pkg.sv @@
// Shared types and codes for the layer z-order manager.
// No dependencies; imported by lzom_cell, lzom_chain and layer_z_order_manager.
`default_nettype none

package lzom_pkg;

    // Level fields are 9-bit signed, -1 meaning hidden / empty.
    localparam int LVL_W  = 9;
    localparam int SLOT_W = 8;
    localparam int POS_W  = 10;

    localparam logic signed [LVL_W-1:0] LVL_NONE = -9'sd1;
    localparam logic signed [POS_W-1:0] POS_NEG1 = -10'sd1;

    // Opcodes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NO_FREE   = 2'd1;
    localparam logic [1:0] ST_UNCHANGED = 2'd2;

    // Control broadcast to every cell of the ring
    typedef struct packed {
        logic                    rotate;   // shift whole ring toward cell 0
        logic                    apply;    // perform the stack/pool edit
        logic                    seg_up;   // 1: segment takes from i-1, 0: from i+1
        logic signed [POS_W-1:0] seg_lo;
        logic signed [POS_W-1:0] seg_hi;
        logic                    ins_en;
        logic [SLOT_W-1:0]       ins_pos;
        logic [SLOT_W-1:0]       ins_val;
        logic                    pool_we;
        logic [SLOT_W-1:0]       pool_idx;
        logic                    pool_val;
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ rtl/lzom_cell.sv @@
// One cell of the ring: a stack slot entry and the pool claim bit for its index.
// Depends on lzom_pkg.
`default_nettype none

module lzom_cell #(
    parameter int IDX = 0,
    parameter int LW  = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire lzom_pkg::t_cell_ctl   i_ctl,
    input  wire logic [LW-1:0]         i_prev_slot,
    input  wire logic [LW-1:0]         i_next_slot,
    input  wire logic                  i_next_used,
    output logic [LW-1:0]              o_slot,
    output logic                       o_used
);
    import lzom_pkg::*;

    localparam logic [SLOT_W-1:0]       CIDX = SLOT_W'(IDX);
    localparam logic signed [POS_W-1:0] CPOS = POS_W'(IDX);

    logic [LW-1:0] r_slot;
    logic [LW-1:0] n_slot;
    logic          r_used;
    logic          n_used;
    logic          in_seg;

    assign in_seg = (CPOS >= i_ctl.seg_lo) && (CPOS <= i_ctl.seg_hi);

    // Slot entry: rotate during the scan, segment shift or insert on apply
    always_comb begin
        n_slot = r_slot;
        if (i_ctl.rotate) begin
            n_slot = i_next_slot;
        end else if (i_ctl.apply) begin
            if (i_ctl.ins_en && (i_ctl.ins_pos == CIDX)) begin
                n_slot = i_ctl.ins_val[LW-1:0];
            end else if (in_seg) begin
                n_slot = i_ctl.seg_up ? i_prev_slot : i_next_slot;
            end
        end
    end

    // Pool claim bit
    always_comb begin
        n_used = r_used;
        if (i_ctl.rotate) begin
            n_used = i_next_used;
        end else if (i_ctl.apply && i_ctl.pool_we && (i_ctl.pool_idx == CIDX)) begin
            n_used = i_ctl.pool_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else begin
            r_used <= n_used;
        end
    end

    assign o_slot = r_slot;
    assign o_used = r_used;

endmodule

`default_nettype wire

@@ rtl/lzom_chain.sv @@
// Ring of LAYERS cells; cell 0 is the head that the sequencer watches.
// Depends on lzom_pkg and lzom_cell.
`default_nettype none

module lzom_chain #(
    parameter int LAYERS = 256,
    parameter int LW     = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire lzom_pkg::t_cell_ctl   i_ctl,
    output logic [LW-1:0]              o_head_slot,
    output logic                       o_head_used
);
    import lzom_pkg::*;

    logic [LW-1:0] w_slot [LAYERS];
    logic          w_used [LAYERS];

    // Each cell sees both neighbors; ends wrap so a full rotation restores order
    for (genvar g = 0; g < LAYERS; g++) begin : g_cell
        lzom_cell #(
            .IDX (g),
            .LW  (LW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (i_ctl),
            .i_prev_slot (w_slot[(g + LAYERS - 1) % LAYERS]),
            .i_next_slot (w_slot[(g + 1) % LAYERS]),
            .i_next_used (w_used[(g + 1) % LAYERS]),
            .o_slot      (w_slot[g]),
            .o_used      (w_used[g])
        );
    end

    assign o_head_slot = w_slot[0];
    assign o_head_used = w_used[0];

endmodule

`default_nettype wire

@@ rtl/layer_z_order_manager.sv @@
// Layer z-order manager: one transaction in, one result out; a new transaction is
// accepted only while idle, after the last result is taken. The stack and the slot pool live in
// a ring of LAYERS cells; each transaction rotates the ring once
// while cell 0 is watched to find the layer's level, its claim bit and the first
// free slot, then the decide state chooses the edit, which is applied to every cell in parallel as the result is shown.
// Depends on lzom_pkg, lzom_chain and layer_z_order_manager_defines.svh.
`default_nettype none
`include "layer_z_order_manager_defines.svh"

module layer_z_order_manager #(
    parameter int LAYERS = 256
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [1:0]                   i_opcode,
    input  wire logic [7:0]                   i_layer,
    input  wire logic signed [8:0]            i_requested_level,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [1:0]                        o_status,
    output logic [7:0]                        o_layer_out,
    output logic signed [8:0]                 o_old_level,
    output logic signed [8:0]                 o_new_level,
    output logic signed [8:0]                 o_top_level,
    output logic                              o_repaint,
    output logic [7:0]                        o_map_from_level,
    output logic [7:0]                        o_paint_low,
    output logic signed [8:0]                 o_paint_high
);
    import lzom_pkg::*;

    localparam int                LW     = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam logic [LW-1:0]     K_LAST = LW'(LAYERS - 1);
    localparam logic [LVL_W-1:0]  NUM_L  = LVL_W'(LAYERS);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_OUT    = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Latched transaction
    logic [1:0]              r_op;
    logic [7:0]              r_lay;
    logic signed [LVL_W-1:0] r_req;
    logic                    r_valid_lay;
    logic [LW-1:0]           r_l;

    // Scan results
    logic [LW-1:0]           r_k;
    logic                    r_found;
    logic [LW-1:0]           r_lvl;
    logic                    r_inuse;
    logic                    r_free_found;
    logic [LW-1:0]           r_free_idx;

    logic signed [LVL_W-1:0] r_top;
    logic signed [LVL_W-1:0] n_top;
    t_cell_ctl               r_ctl;
    t_cell_ctl               n_ctl;
    t_cell_ctl               ctl;

    // Result registers
    logic [1:0]              r_status;
    logic [7:0]              r_layer_out;
    logic signed [LVL_W-1:0] r_old;
    logic signed [LVL_W-1:0] r_new;
    logic                    r_rep;
    logic [7:0]              r_map;
    logic [7:0]              r_plo;
    logic signed [LVL_W-1:0] r_phi;

    logic [1:0]              n_status;
    logic [7:0]              n_layer_out;
    logic signed [LVL_W-1:0] n_old;
    logic signed [LVL_W-1:0] n_new;
    logic                    n_rep;
    logic [7:0]              n_map;
    logic [7:0]              n_plo;
    logic signed [LVL_W-1:0] n_phi;

    logic [LW-1:0]           head_slot;
    logic                    head_used;
    logic                    accept;
    logic                    k_in_stack;

    logic signed [POS_W-1:0] old10;
    logic signed [POS_W-1:0] top10;
    logic signed [POS_W-1:0] req10;
    logic signed [POS_W-1:0] lim10;
    logic signed [POS_W-1:0] nl10;
    logic signed [POS_W-1:0] nlc10;

    assign accept     = i_valid && o_ready;
    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = (r_state == S_OUT);
    assign k_in_stack = ($signed(LVL_W'(r_k)) <= r_top);

    // Ring of cells
    always_comb begin
        ctl        = r_ctl;
        ctl.rotate = (r_state == S_SCAN);
    end

    lzom_chain #(
        .LAYERS (LAYERS),
        .LW     (LW)
    ) u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_head_slot (head_slot),
        .o_head_used (head_used)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_valid) n_state = S_SCAN;
            S_SCAN:   if (r_k == K_LAST) n_state = S_DECIDE;
            S_DECIDE: n_state = S_OUT;
            S_OUT:    if (i_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_top   <= LVL_NONE;
            r_ctl   <= '0;
        end else begin
            r_state   <= n_state;
            r_ctl     <= n_ctl;
            if (r_state == S_DECIDE) begin
                r_top <= n_top;
            end
        end
    end

    // Latch transaction and watch the head of the ring during rotation
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op         <= i_opcode;
            r_lay        <= i_layer;
            r_req        <= i_requested_level;
            r_valid_lay  <= ({1'b0, i_layer} < NUM_L);
            r_l          <= ({1'b0, i_layer} < NUM_L) ? i_layer[LW-1:0] : '0;
            r_k          <= '0;
            r_found      <= 1'b0;
            r_inuse      <= 1'b0;
            r_free_found <= 1'b0;
        end else if (r_state == S_SCAN) begin
            r_k <= r_k + 1'b1;
            if (k_in_stack && (head_slot == r_l)) begin
                r_found <= 1'b1;
                r_lvl   <= r_k;
            end
            if (r_k == r_l) begin
                r_inuse <= head_used;
            end
            if (!head_used && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_k;
            end
        end
    end

    // Level arithmetic on 10-bit signed values
    always_comb begin
        old10 = r_found ? $signed(POS_W'(r_lvl)) : POS_NEG1;
        top10 = $signed({r_top[LVL_W-1], r_top});
        req10 = $signed({r_req[LVL_W-1], r_req});
        lim10 = (old10 >= 10'sd0) ? top10 : top10 + 10'sd1;
        nlc10 = (req10 > lim10) ? lim10 : req10;
        nl10  = (nlc10 < POS_NEG1) ? POS_NEG1 : nlc10;
    end

    // Decide the edit and the result; the edit is applied in the cycle after decide
    always_comb begin
        n_ctl          = '0;
        n_ctl.apply    = (r_state == S_DECIDE);
        n_ctl.seg_lo   = 10'sd0;
        n_ctl.seg_hi   = POS_NEG1;
        n_ctl.ins_val  = SLOT_W'(r_l);
        n_ctl.ins_pos  = nl10[SLOT_W-1:0];
        n_ctl.pool_idx = SLOT_W'(r_l);
        n_top          = r_top;
        n_status       = ST_UNCHANGED;
        n_layer_out    = r_lay;
        n_old          = LVL_NONE;
        n_new          = LVL_NONE;
        n_rep          = 1'b0;
        n_map          = 8'd0;
        n_plo          = 8'd0;
        n_phi          = LVL_NONE;

        if (r_op == OP_ALLOC) begin
            n_ctl.pool_we  = r_free_found;
            n_ctl.pool_idx = SLOT_W'(r_free_idx);
            n_ctl.pool_val = 1'b1;
            n_status       = r_free_found ? ST_DONE : ST_NO_FREE;
            n_layer_out    = r_free_found ? 8'(r_free_idx) : 8'd0;
        end else if (r_valid_lay) begin
            n_old = old10[LVL_W-1:0];
            n_new = old10[LVL_W-1:0];
            unique case (r_op)
                OP_FREE: begin
                    n_ctl.pool_we = 1'b1;
                    n_status      = ST_DONE;
                    if (r_found) begin
                        // hide: close the gap above old
                        n_ctl.seg_lo = old10;
                        n_ctl.seg_hi = top10 - 10'sd1;
                        n_top        = LVL_W'(top10 - 10'sd1);
                        n_new        = LVL_NONE;
                        n_rep        = 1'b1;
                        n_phi        = LVL_W'(old10 - 10'sd1);
                    end
                end
                OP_SET: begin
                    if (r_inuse && (nl10 != old10)) begin
                        n_status = ST_DONE;
                        n_rep    = 1'b1;
                        n_new    = nl10[LVL_W-1:0];
                        if (nl10 < 10'sd0) begin
                            // hide
                            n_ctl.seg_lo = old10;
                            n_ctl.seg_hi = top10 - 10'sd1;
                            n_top        = LVL_W'(top10 - 10'sd1);
                            n_phi        = LVL_W'(old10 - 10'sd1);
                        end else if (old10 < 10'sd0) begin
                            // show: open a gap at nl
                            n_ctl.seg_up = 1'b1;
                            n_ctl.seg_lo = nl10 + 10'sd1;
                            n_ctl.seg_hi = top10 + 10'sd1;
                            n_ctl.ins_en = 1'b1;
                            n_top        = LVL_W'(top10 + 10'sd1);
                            n_map        = nl10[7:0];
                            n_plo        = nl10[7:0];
                            n_phi        = nl10[LVL_W-1:0];
                        end else if (old10 > nl10) begin
                            // lower
                            n_ctl.seg_up = 1'b1;
                            n_ctl.seg_lo = nl10 + 10'sd1;
                            n_ctl.seg_hi = old10;
                            n_ctl.ins_en = 1'b1;
                            n_map        = 8'(nl10 + 10'sd1);
                            n_plo        = 8'(nl10 + 10'sd1);
                            n_phi        = old10[LVL_W-1:0];
                        end else begin
                            // raise
                            n_ctl.seg_lo = old10;
                            n_ctl.seg_hi = nl10 - 10'sd1;
                            n_ctl.ins_en = 1'b1;
                            n_map        = nl10[7:0];
                            n_plo        = nl10[7:0];
                            n_phi        = nl10[LVL_W-1:0];
                        end
                    end
                end
                default: begin
                    // no operation: report the current level
                end
            endcase
        end
    end

    // Result register, loaded once per transaction
    always_ff @(posedge i_clk) begin
        if (r_state == S_DECIDE) begin
            r_status    <= n_status;
            r_layer_out <= n_layer_out;
            r_old       <= n_old;
            r_new       <= n_new;
            r_rep       <= n_rep;
            r_map       <= n_map;
            r_plo       <= n_plo;
            r_phi       <= n_phi;
        end
    end

    assign o_status         = r_status;
    assign o_layer_out      = r_layer_out;
    assign o_old_level      = r_old;
    assign o_new_level      = r_new;
    assign o_top_level      = r_top;
    assign o_repaint        = r_rep;
    assign o_map_from_level = r_map;
    assign o_paint_low      = r_plo;
    assign o_paint_high     = r_phi;

    // Checks
    `LZOM_ASSERT_NEXT(a_scan_start, i_clk, i_rst_n, accept, (r_state == S_SCAN) && (r_k == '0), "scan must start at head")
    `LZOM_ASSERT_NEXT(a_scan_end, i_clk, i_rst_n, (r_state == S_SCAN) && (r_k == K_LAST), r_state == S_DECIDE, "scan must end after one rotation")
    `LZOM_ASSERT_NEXT(a_apply_once, i_clk, i_rst_n, r_state == S_DECIDE, r_ctl.apply && o_valid, "edit must coincide with result")
    `LZOM_ASSERT_NOW(a_no_rotate_edit, i_clk, i_rst_n, r_state == S_SCAN, !r_ctl.apply, "edit during rotation")

endmodule

`default_nettype wire
